// ----- hw/rtl/jce_pkg.sv -----
// Shared types and constants for the Josephus circle eliminator.
`timescale 1ns / 1ps
`default_nettype none

package jce_pkg;

  localparam int unsigned PL_W       = 9;
  localparam int unsigned SKIP_W     = 16;
  localparam int unsigned BITCNT_W   = $clog2(SKIP_W);
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned APB_AW     = 3;

  localparam logic [0:0]      REG_CIRCLE_SIZE = 1'b0;
  localparam logic [PL_W-1:0] CIRCLE_SIZE_RST = 9'd8;

  typedef struct packed {
    logic init;
    logic sweep;
    logic load;
    logic div_step;
    logic walk_step;
    logic commit;
  } jce_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic sweep_last;
    logic empty;
    logic div_last;
    logic walk_zero;
  } jce_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/jce_datapath.sv -----
// Datapath: link memory, walk registers, remainder unit and result register.
`timescale 1ns / 1ps
`default_nettype none

module jce_datapath #(
  parameter int unsigned MAX_PEOPLE = 256
) (
  input  wire logic                        clk,
  input  wire jce_pkg::jce_cmd_t           cmd,
  output jce_pkg::jce_sts_t                sts,
  input  wire logic [jce_pkg::PL_W-1:0]    circle_size,
  input  wire logic [jce_pkg::SKIP_W-1:0]  skip_count,
  output logic      [jce_pkg::PL_W-1:0]    eliminated_id,
  output logic      [jce_pkg::PL_W-1:0]    remaining,
  output logic                             empty_error
);
  import jce_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_PEOPLE);
  localparam int unsigned CMP_W = ((IDX_W > PL_W) ? IDX_W : PL_W) + 1;
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_PEOPLE);

  logic [IDX_W-1:0] link_mem [MAX_PEOPLE];
  logic [IDX_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;

  logic [IDX_W-1:0] cur_r;
  logic [IDX_W-1:0] prev_r;
  logic [PL_W-1:0]  people_left_r;
  logic [IDX_W-1:0] sweep_idx_r;

  logic [SKIP_W-1:0]   div_q_r;
  logic [PL_W-1:0]     rem_r;
  logic [BITCNT_W-1:0] bit_cnt_r;

  logic [PL_W-1:0] elim_r;
  logic [PL_W-1:0] remain_r;
  logic            err_r;

  logic [CMP_W-1:0] size_c;
  logic [CMP_W-1:0] n_eff;
  logic [CMP_W-1:0] n_last;
  logic [IDX_W-1:0] sweep_wdata;
  logic [PL_W:0]    trial;
  logic [PL_W:0]    diff;
  logic [PL_W-1:0]  rem_nxt;
  logic [CMP_W-1:0] victim_id;

  assign size_c      = CMP_W'(circle_size);
  assign n_eff       = (size_c > MAX_C) ? MAX_C : size_c;
  assign n_last      = n_eff - CMP_W'(1);
  assign sweep_wdata = (CMP_W'(sweep_idx_r) == n_last) ? '0 : sweep_idx_r + IDX_W'(1);

  assign trial   = {rem_r, div_q_r[SKIP_W-1]};
  assign diff    = trial - {1'b0, people_left_r};
  assign rem_nxt = (trial >= {1'b0, people_left_r}) ? diff[PL_W-1:0] : trial[PL_W-1:0];

  assign victim_id = CMP_W'(cur_r) + CMP_W'(1);
  assign rd_addr   = cmd.walk_step ? rd_data_r : cur_r;

  assign sts.n_zero     = (n_eff == '0);
  assign sts.sweep_last = (CMP_W'(sweep_idx_r) == n_last);
  assign sts.empty      = (people_left_r == '0);
  assign sts.div_last   = (bit_cnt_r == {BITCNT_W{1'b1}});
  assign sts.walk_zero  = (rem_r == '0);

  always_ff @(posedge clk) begin
    rd_data_r <= link_mem[rd_addr];
    if (cmd.sweep) begin
      link_mem[sweep_idx_r] <= sweep_wdata;
    end else if (cmd.commit && !sts.empty) begin
      link_mem[prev_r] <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      cur_r         <= '0;
      prev_r        <= sts.n_zero ? '0 : n_last[IDX_W-1:0];
      people_left_r <= n_eff[PL_W-1:0];
      sweep_idx_r   <= '0;
    end
    if (cmd.sweep) begin
      sweep_idx_r <= sweep_idx_r + IDX_W'(1);
    end
    if (cmd.load) begin
      div_q_r   <= (skip_count == '0) ? '0 : skip_count - SKIP_W'(1);
      rem_r     <= '0;
      bit_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      div_q_r   <= {div_q_r[SKIP_W-2:0], 1'b0};
      rem_r     <= rem_nxt;
      bit_cnt_r <= bit_cnt_r + BITCNT_W'(1);
    end
    if (cmd.walk_step) begin
      rem_r  <= rem_r - PL_W'(1);
      prev_r <= cur_r;
      cur_r  <= rd_data_r;
    end
    if (cmd.commit) begin
      if (sts.empty) begin
        elim_r   <= '0;
        remain_r <= '0;
        err_r    <= 1'b1;
      end else begin
        elim_r        <= victim_id[PL_W-1:0];
        remain_r      <= people_left_r - PL_W'(1);
        err_r         <= 1'b0;
        people_left_r <= people_left_r - PL_W'(1);
        cur_r         <= rd_data_r;
      end
    end
  end

  assign eliminated_id = elim_r;
  assign remaining     = remain_r;
  assign empty_error   = err_r;

endmodule

`default_nettype wire

// ----- hw/rtl/jce_ctrl.sv -----
// Controller state machine: refill sweep, remainder, walk and commit sequencing.
`timescale 1ns / 1ps
`default_nettype none

module jce_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire jce_pkg::jce_sts_t sts,
  output jce_pkg::jce_cmd_t      cmd
);
  import jce_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_SWEEP,
    ST_IDLE,
    ST_DIV,
    ST_WALK,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && !cfg_wr;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = sts.n_zero ? ST_IDLE : ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid && !cfg_wr) begin
          cmd.load  = 1'b1;
          state_nxt = sts.empty ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts.walk_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
    if (cfg_wr) begin
      state_nxt = ST_INIT;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/josephus_circle_eliminator.sv -----
// Top level of the Josephus circle eliminator: register port, controller and datapath.
//
// Channel   Dir  Handshake                        Fields
// in_       in   in_valid / in_ready              in_skip_count[15:0]
// out_      out  out_valid / out_ready            out_eliminated_id[8:0], out_remaining[8:0],
//                                                 out_empty_error
// config    in   psel, penable, pwrite, pready    paddr[2:0], pwdata[31:0], prdata[31:0]
//
// A request on an empty circle goes straight to commit; otherwise the bit-serial
// remainder unit runs over the 16-bit skip count, then the walk follows one link per
// cycle, at most people_left-1 links, set by the single read port of the link memory,
// then commits. After reset and after every write of circle_size, a sweep rewrites
// the links of min(circle_size, MAX_PEOPLE) people, during which no request is
// accepted. A finished result waits in the output register; the next request is
// taken meanwhile and stalls only at commit until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module josephus_circle_eliminator #(
  parameter int unsigned MAX_PEOPLE = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [jce_pkg::SKIP_W-1:0]   in_skip_count,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [jce_pkg::PL_W-1:0]     out_eliminated_id,
  output logic      [jce_pkg::PL_W-1:0]     out_remaining,
  output logic                              out_empty_error,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [jce_pkg::APB_AW-1:0]   paddr,
  input  wire logic [jce_pkg::APB_DW-1:0]   pwdata,
  output logic      [jce_pkg::APB_DW-1:0]   prdata,
  output logic                              pready
);
  import jce_pkg::*;

  logic [PL_W-1:0] circle_size_r;
  logic            cfg_wr;
  jce_cmd_t        cmd;
  jce_sts_t        sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CIRCLE_SIZE);
  assign prdata = (paddr[2] == REG_CIRCLE_SIZE) ? APB_DW'(circle_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      circle_size_r <= CIRCLE_SIZE_RST;
    end else if (cfg_wr) begin
      circle_size_r <= pwdata[PL_W-1:0];
    end
  end

  jce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  jce_datapath #(
    .MAX_PEOPLE (MAX_PEOPLE)
  ) u_datapath (
    .clk           (clk),
    .cmd           (cmd),
    .sts           (sts),
    .circle_size   (circle_size_r),
    .skip_count    (in_skip_count),
    .eliminated_id (out_eliminated_id),
    .remaining     (out_remaining),
    .empty_error   (out_empty_error)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/jce_checker.sv -----
// Port-level checker for the Josephus circle eliminator and its bind.
`timescale 1ns / 1ps
`default_nettype none

module jce_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [jce_pkg::PL_W-1:0]     out_eliminated_id,
  input wire logic [jce_pkg::PL_W-1:0]     out_remaining,
  input wire logic                         out_empty_error,
  input wire logic                         psel,
  input wire logic                         penable,
  input wire logic                         pwrite,
  input wire logic [jce_pkg::APB_AW-1:0]   paddr,
  input wire logic                         pready
);
  import jce_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_eliminated_id)
      && $stable(out_remaining) && $stable(out_empty_error))
    else $error("Stalled result changed or dropped.");

  a_error_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_error |-> out_eliminated_id == '0 && out_remaining == '0)
    else $error("Empty-circle result carries a person or a count.");

  a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_empty_error |-> out_eliminated_id != '0)
    else $error("Removed person has id zero.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Request taken while the previous one is in progress.");

  a_refill_busy: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && (paddr[2] == REG_CIRCLE_SIZE) |=> !in_ready)
    else $error("Request taken during refill.");

endmodule

bind josephus_circle_eliminator jce_checker u_jce_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_eliminated_id (out_eliminated_id),
  .out_remaining     (out_remaining),
  .out_empty_error   (out_empty_error),
  .psel              (psel),
  .penable           (penable),
  .pwrite            (pwrite),
  .paddr             (paddr),
  .pready            (pready)
);

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the Josephus circle eliminator with a built-in circle predictor.
`timescale 1ns / 1ps

module tb;
  import jce_pkg::*;

  localparam int unsigned PEOPLE_CAP    = 256;
  localparam int unsigned RANDOM_ITEMS  = 600;
  localparam int unsigned QUIET_ITEMS   = 80;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned TAIL_CYCLES   = 300;
  localparam logic [APB_AW-1:0] CIRCLE_SIZE_ADDR = {REG_CIRCLE_SIZE, 2'b00};
  localparam logic [APB_AW-1:0] UNMAPPED_ADDR    = {~REG_CIRCLE_SIZE, 2'b00};

  typedef struct packed {
    logic [PL_W-1:0] id;
    logic [PL_W-1:0] left;
    logic            empty;
  } elimination_t;

  class elimination_book;
    logic [7:0]      succ[PEOPLE_CAP];
    logic [7:0]      current;
    logic [7:0]      behind;
    logic [PL_W-1:0] people;
    logic [PL_W-1:0] circle_size;
    elimination_t    pending[$];
    int unsigned     mismatches;
    int unsigned     removals;
    int unsigned     empties;

    function new();
      circle_size = CIRCLE_SIZE_RST;
      refill();
    endfunction

    function void refill();
      int unsigned n;
      n = (circle_size > PEOPLE_CAP) ? PEOPLE_CAP : circle_size;
      for (int i = 0; i < PEOPLE_CAP; i++) succ[i] = 8'(i + 1);
      if (n > 0) succ[n - 1] = 8'd0;
      current = 8'd0;
      behind  = (n > 0) ? 8'(n - 1) : 8'd0;
      people  = PL_W'(n);
    endfunction

    function void write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
      if (addr == CIRCLE_SIZE_ADDR) begin
        circle_size = data[PL_W-1:0];
        refill();
      end
    endfunction

    // Walks the survivor ring for one accepted request and records the elimination it causes.
    function void take_skip(logic [SKIP_W-1:0] k);
      elimination_t r;
      int unsigned  steps;
      logic [7:0]   victim;
      if (people == 0) begin
        r.id    = '0;
        r.left  = '0;
        r.empty = 1'b1;
      end else begin
        steps = (k == 0) ? 0 : (int'(k) - 1) % int'(people);
        for (int unsigned s = 0; s < steps; s++) begin
          behind  = current;
          current = succ[current];
        end
        victim       = current;
        succ[behind] = succ[victim];
        people       = people - 1'b1;
        current      = succ[victim];
        r.id         = PL_W'(victim) + 1'b1;
        r.left       = people;
        r.empty      = 1'b0;
      end
      pending.push_back(r);
    endfunction

    function void match_elimination(logic [PL_W-1:0] id, logic [PL_W-1:0] left, logic empty);
      elimination_t want;
      if (pending.size() == 0) begin
        $error("Unexpected result: eliminated_id %0d remaining %0d empty_error %0d",
               id, left, empty);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (id !== want.id) begin
        $error("eliminated_id mismatch: expected %0d, actual %0d", want.id, id);
        mismatches++;
      end
      if (left !== want.left) begin
        $error("remaining mismatch: expected %0d, actual %0d", want.left, left);
        mismatches++;
      end
      if (empty !== want.empty) begin
        $error("empty_error mismatch: expected %0d, actual %0d", want.empty, empty);
        mismatches++;
      end
      if (want.empty) empties++;
      else removals++;
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [SKIP_W-1:0] in_skip_count = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [PL_W-1:0]   out_eliminated_id;
  logic [PL_W-1:0]   out_remaining;
  logic              out_empty_error;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  elimination_book book;
  bit              quiet = 1'b0;
  int unsigned     sent = 0;

  josephus_circle_eliminator #(.MAX_PEOPLE(PEOPLE_CAP)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_skip_count    (in_skip_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_eliminated_id(out_eliminated_id),
    .out_remaining    (out_remaining),
    .out_empty_error  (out_empty_error),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      book.match_elimination(out_eliminated_id, out_remaining, out_empty_error);
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 40)) @(negedge clk);
    end
  end

  initial begin
    int unsigned dead_cycles;
    dead_cycles = 0;
    while (dead_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
        dead_cycles = 0;
      end else begin
        dead_cycles++;
      end
    end
    $error("No request or result moved for %0d cycles.", STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_skip(input logic [SKIP_W-1:0] k);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_skip_count <= k;
    do @(posedge clk); while (!in_ready);
    book.take_skip(k);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (book.pending.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    book.write_reg(addr, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_check();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CIRCLE_SIZE_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DW'(book.circle_size)) begin
      $error("circle_size readback mismatch: expected %0d, actual %0d",
             book.circle_size, prdata);
      book.mismatches++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [SKIP_W-1:0] pick_skip();
    case ($urandom_range(0, 9))
      0:       return SKIP_W'($urandom_range(0, 1));
      1, 2:    return SKIP_W'($urandom());
      default: return SKIP_W'($urandom_range(0, 2 * book.people + 2));
    endcase
  endfunction

  task automatic run_circle(input logic [PL_W-1:0] n, input int unsigned count);
    drain();
    cfg_write(CIRCLE_SIZE_ADDR, APB_DW'(n));
    cfg_check();
    for (int unsigned i = 0; i < count; i++) begin
      // Now and then the sender holds off until every request has been answered.
      if (!quiet && $urandom_range(0, 39) == 0) drain();
      send_skip(pick_skip());
    end
    drain();
  endtask

  initial begin
    logic [SKIP_W-1:0] opening[9];
    logic [PL_W-1:0]   n;
    int unsigned       phase;
    int unsigned       total;
    int unsigned       count;

    opening = '{16'd0, 16'd1, 16'd2, 16'hFFFF, 16'h8000, 16'h5555, 16'hAAAA, 16'd3, 16'd7};
    book = new();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // The reset circle of eight is emptied, and one more request hits the empty circle.
    foreach (opening[i]) send_skip(opening[i]);
    drain();
    cfg_write(CIRCLE_SIZE_ADDR, 32'd0);
    cfg_check();
    send_skip(16'd5);
    drain();
    cfg_write(CIRCLE_SIZE_ADDR, 32'd1);
    send_skip(16'hFFFF);
    send_skip(16'd0);
    drain();
    cfg_write(CIRCLE_SIZE_ADDR, 32'd3);
    send_skip(16'd2);
    drain();
    cfg_write(UNMAPPED_ADDR, 32'd5);
    cfg_check();
    send_skip(16'd1);
    send_skip(16'd4);
    send_skip(16'd9);

    total = sent + RANDOM_ITEMS;
    phase = 0;
    while (sent < total) begin
      if (sent + QUIET_ITEMS >= total) quiet = 1'b1;
      case (phase)
        0: n = 9'd511;
        1: n = 9'd256;
        2: n = 9'd2;
        default: begin
          case ($urandom_range(0, 19))
            0:       n = 9'd0;
            1:       n = PL_W'($urandom_range(257, 511));
            2:       n = 9'd256;
            default: n = PL_W'($urandom_range(1, 40));
          endcase
        end
      endcase
      if (phase == 0) count = PEOPLE_CAP + 2;
      else if (n > 64) count = $urandom_range(20, 60);
      else count = n + $urandom_range(0, 2);
      run_circle(n, count);
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d requests over %0d circle refills: %0d people eliminated, %0d empty-circle errors.",
             sent, phase + 4, book.removals, book.empties);
    if (book.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
